// ----- sv/segint_pkg.sv -----
`default_nettype none

package segint_pkg;

   localparam int unsigned COORD_WIDTH_DEF = 16;

   // orientation of point r against the directed line p -> q
   typedef enum logic [1:0] {
      ORIENT_COLLINEAR = 2'd0,
      ORIENT_CW        = 2'd1,
      ORIENT_CCW       = 2'd2
   } orient_type;

   // stage load enables shared by the orientation units
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } segint_ctl_type;

endpackage

`default_nettype wire

// ----- sv/segint_req_if.sv -----
`default_nettype none

interface segint_req_if import segint_pkg::*; #(
   parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_start_x;
   logic signed [COORD_WIDTH-1:0] first_start_y;
   logic signed [COORD_WIDTH-1:0] first_end_x;
   logic signed [COORD_WIDTH-1:0] first_end_y;
   logic signed [COORD_WIDTH-1:0] second_start_x;
   logic signed [COORD_WIDTH-1:0] second_start_y;
   logic signed [COORD_WIDTH-1:0] second_end_x;
   logic signed [COORD_WIDTH-1:0] second_end_y;

   modport source (
      output valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      input  ready
   );
   modport sink (
      input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      output ready
   );
endinterface

`default_nettype wire

// ----- sv/segint_rsp_if.sv -----
`default_nettype none

interface segint_rsp_if;
   logic valid;
   logic ready;
   logic segments_intersect;

   modport source (output valid, segments_intersect, input ready);
   modport sink (input valid, segments_intersect, output ready);
endinterface

`default_nettype wire

// ----- sv/segint_orient.sv -----
`default_nettype none

// orient(p, q, r): sign of (q.y-p.y)*(r.x-q.x) - (q.x-p.x)*(r.y-q.y)
// stage 1 differences, stage 2 products, stage 3 compare
module segint_orient import segint_pkg::*; #(
   parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire segint_ctl_type                ctl,
   input  wire logic signed [COORD_WIDTH-1:0] p_x,
   input  wire logic signed [COORD_WIDTH-1:0] p_y,
   input  wire logic signed [COORD_WIDTH-1:0] q_x,
   input  wire logic signed [COORD_WIDTH-1:0] q_y,
   input  wire logic signed [COORD_WIDTH-1:0] r_x,
   input  wire logic signed [COORD_WIDTH-1:0] r_y,
   output orient_type                         orient
);
   localparam int unsigned DW = COORD_WIDTH + 1;
   localparam int unsigned PW = 2 * DW;

   logic signed [DW-1:0] dqy_ff, drx_ff, dqx_ff, dry_ff;
   logic signed [DW-1:0] dqy_in, drx_in, dqx_in, dry_in;
   logic signed [PW-1:0] lhs_ff, rhs_ff, lhs_in, rhs_in;
   orient_type           orient_ff, orient_in;

   always_comb begin
      dqy_in = DW'(q_y) - DW'(p_y);
      drx_in = DW'(r_x) - DW'(q_x);
      dqx_in = DW'(q_x) - DW'(p_x);
      dry_in = DW'(r_y) - DW'(q_y);
      lhs_in = PW'(dqy_ff) * PW'(drx_ff);
      rhs_in = PW'(dqx_ff) * PW'(dry_ff);
      if (lhs_ff == rhs_ff) begin
         orient_in = ORIENT_COLLINEAR;
      end else if (lhs_ff > rhs_ff) begin
         orient_in = ORIENT_CW;
      end else begin
         orient_in = ORIENT_CCW;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         dqy_ff <= dqy_in;
         drx_ff <= drx_in;
         dqx_ff <= dqx_in;
         dry_ff <= dry_in;
      end
      if (ctl.s2_en) begin
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
      end
      if (ctl.s3_en) begin
         orient_ff <= orient_in;
      end
   end

   assign orient = orient_ff;

endmodule

`default_nettype wire

// ----- sv/segment_intersection_test.sv -----
// An accepted item passes through the stages below to its result at the output register.
// Throughput: one segment pair per cycle; four stages (differences, products,
// compare, decision), each holding while the stage after it is full and stalled.
// Synchronous active-high reset clears all stage valid bits; data regs are not reset.
`default_nettype none

module segment_intersection_test import segint_pkg::*; #(
   parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   segint_req_if.sink   req_ch,
   segint_rsp_if.source rsp_ch
);
   localparam int unsigned NUM_TESTS = 4;

   logic v1_ff, v2_ff, v3_ff, vout_ff;
   logic rdy1, rdy2, rdy3, rdy_out;
   segint_ctl_type ctl;

   logic [NUM_TESTS-1:0] box1_ff, box2_ff, box3_ff, box_in;
   logic                 hit_ff, hit_in;
   orient_type           o1, o2, o3, o4;

   // ready ripples back: a stage takes new data when empty or draining
   always_comb begin
      rdy_out   = !vout_ff || rsp_ch.ready;
      rdy3      = !v3_ff || rdy_out;
      rdy2      = !v2_ff || rdy3;
      rdy1      = !v1_ff || rdy2;
      ctl.s1_en = rdy1;
      ctl.s2_en = rdy2;
      ctl.s3_en = rdy3;
   end

   assign req_ch.ready = rdy1;

   function automatic logic in_box(
      input logic signed [COORD_WIDTH-1:0] ax, ay, tx, ty, bx, by
   );
      in_box = (tx <= ax || tx <= bx) && (tx >= ax || tx >= bx) &&
               (ty <= ay || ty <= by) && (ty >= ay || ty >= by);
   endfunction

   always_comb begin
      box_in[0] = in_box(req_ch.first_start_x, req_ch.first_start_y,
                         req_ch.second_start_x, req_ch.second_start_y,
                         req_ch.first_end_x, req_ch.first_end_y);
      box_in[1] = in_box(req_ch.first_start_x, req_ch.first_start_y,
                         req_ch.second_end_x, req_ch.second_end_y,
                         req_ch.first_end_x, req_ch.first_end_y);
      box_in[2] = in_box(req_ch.second_start_x, req_ch.second_start_y,
                         req_ch.first_start_x, req_ch.first_start_y,
                         req_ch.second_end_x, req_ch.second_end_y);
      box_in[3] = in_box(req_ch.second_start_x, req_ch.second_start_y,
                         req_ch.first_end_x, req_ch.first_end_y,
                         req_ch.second_end_x, req_ch.second_end_y);
   end

   segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient1 (
      .clock(clock), .ctl(ctl),
      .p_x(req_ch.first_start_x), .p_y(req_ch.first_start_y),
      .q_x(req_ch.first_end_x), .q_y(req_ch.first_end_y),
      .r_x(req_ch.second_start_x), .r_y(req_ch.second_start_y),
      .orient(o1)
   );

   segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient2 (
      .clock(clock), .ctl(ctl),
      .p_x(req_ch.first_start_x), .p_y(req_ch.first_start_y),
      .q_x(req_ch.first_end_x), .q_y(req_ch.first_end_y),
      .r_x(req_ch.second_end_x), .r_y(req_ch.second_end_y),
      .orient(o2)
   );

   segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient3 (
      .clock(clock), .ctl(ctl),
      .p_x(req_ch.second_start_x), .p_y(req_ch.second_start_y),
      .q_x(req_ch.second_end_x), .q_y(req_ch.second_end_y),
      .r_x(req_ch.first_start_x), .r_y(req_ch.first_start_y),
      .orient(o3)
   );

   segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient4 (
      .clock(clock), .ctl(ctl),
      .p_x(req_ch.second_start_x), .p_y(req_ch.second_start_y),
      .q_x(req_ch.second_end_x), .q_y(req_ch.second_end_y),
      .r_x(req_ch.first_end_x), .r_y(req_ch.first_end_y),
      .orient(o4)
   );

   // proper crossing, or a collinear end point inside the other box
   always_comb begin
      hit_in = (o1 != o2 && o3 != o4) ||
               (o1 == ORIENT_COLLINEAR && box3_ff[0]) ||
               (o2 == ORIENT_COLLINEAR && box3_ff[1]) ||
               (o3 == ORIENT_COLLINEAR && box3_ff[2]) ||
               (o4 == ORIENT_COLLINEAR && box3_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_ch.valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy_out) begin
            vout_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         box1_ff <= box_in;
      end
      if (rdy2) begin
         box2_ff <= box1_ff;
      end
      if (rdy3) begin
         box3_ff <= box2_ff;
      end
      if (rdy_out) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_ch.valid              = vout_ff;
   assign rsp_ch.segments_intersect = hit_ff;

endmodule

`default_nettype wire

// ----- sv/segint_chk.sv -----
`default_nettype none

module segint_chk (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_hit
);
   logic req_take;

   assign req_take = req_valid && req_ready;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
      else $error("stalled result dropped or changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // with the output draining, each accepted item comes out through v1, v2, v3 and the output register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready && $past(rsp_ready) && $past(rsp_ready, 2) &&
       $past(rsp_ready, 3) && $past(rsp_ready, 4) &&
       !$past(reset) && !$past(reset, 2) && !$past(reset, 3) && !$past(reset, 4))
      |-> rsp_valid == $past(req_take, 4))
      else $error("item lost, repeated or late in the pipeline");

endmodule

bind segment_intersection_test segint_chk u_segint_chk (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_hit(rsp_ch.segments_intersect)
);

`default_nettype wire

// ----- bench/segint_checker.sv -----
`timescale 1ns / 1ps

module segint_checker import segint_pkg::*; #(
   parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   segint_req_if      req_ch,
   segint_rsp_if      rsp_ch,
   output int unsigned fail_count,
   output int unsigned pending_count,
   output int unsigned checked_count,
   output int unsigned hit_count
);

   typedef struct {
      longint x;
      longint y;
   } point_type;

   bit meet_q[$];

   // products of 17-bit differences fit easily in 64 bits
   function automatic orient_type orientation_of(point_type p, point_type q, point_type r);
      longint lhs;
      longint rhs;
      lhs = (q.y - p.y) * (r.x - q.x);
      rhs = (q.x - p.x) * (r.y - q.y);
      if (lhs == rhs) return ORIENT_COLLINEAR;
      return (lhs > rhs) ? ORIENT_CW : ORIENT_CCW;
   endfunction

   function automatic bit within_box(point_type a, point_type t, point_type b);
      return t.x <= ((a.x > b.x) ? a.x : b.x) && t.x >= ((a.x < b.x) ? a.x : b.x) &&
             t.y <= ((a.y > b.y) ? a.y : b.y) && t.y >= ((a.y < b.y) ? a.y : b.y);
   endfunction

   function automatic bit segments_meet(point_type a0, point_type a1,
                                        point_type b0, point_type b1);
      orient_type o1;
      orient_type o2;
      orient_type o3;
      orient_type o4;
      o1 = orientation_of(a0, a1, b0);
      o2 = orientation_of(a0, a1, b1);
      o3 = orientation_of(b0, b1, a0);
      o4 = orientation_of(b0, b1, a1);
      if (o1 != o2 && o3 != o4) return 1'b1;
      // collinear triples: the tested end point must sit inside the other box
      if (o1 == ORIENT_COLLINEAR && within_box(a0, b0, a1)) return 1'b1;
      if (o2 == ORIENT_COLLINEAR && within_box(a0, b1, a1)) return 1'b1;
      if (o3 == ORIENT_COLLINEAR && within_box(b0, a0, b1)) return 1'b1;
      if (o4 == ORIENT_COLLINEAR && within_box(b0, a1, b1)) return 1'b1;
      return 1'b0;
   endfunction

   function automatic point_type make_point(logic signed [COORD_WIDTH-1:0] x,
                                            logic signed [COORD_WIDTH-1:0] y);
      point_type pt;
      pt.x = longint'(x);
      pt.y = longint'(y);
      return pt;
   endfunction

   task automatic report_mismatch(string what);
      fail_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         meet_q.delete();
         fail_count    = 0;
         checked_count = 0;
         hit_count     = 0;
         pending_count <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (meet_q.size() == 0) begin
               report_mismatch($sformatf("result %0b arrived with no item outstanding",
                                         rsp_ch.segments_intersect));
            end else begin
               want = meet_q.pop_front();
               if (want) hit_count++;
               if (rsp_ch.segments_intersect !== want)
                  report_mismatch($sformatf("item %0d: segments_intersect %b, expected %0b",
                                            checked_count, rsp_ch.segments_intersect, want));
               checked_count++;
            end
         end
         if (req_ch.valid && req_ch.ready)
            meet_q.push_back(segments_meet(
               make_point(req_ch.first_start_x, req_ch.first_start_y),
               make_point(req_ch.first_end_x, req_ch.first_end_y),
               make_point(req_ch.second_start_x, req_ch.second_start_y),
               make_point(req_ch.second_end_x, req_ch.second_end_y)));
         pending_count <= meet_q.size();
      end
   end

endmodule

// ----- bench/tb_segment_intersection_test.sv -----
`timescale 1ns / 1ps

module tb_segment_intersection_test;
   import segint_pkg::*;

   localparam int unsigned CW         = COORD_WIDTH_DEF;
   localparam int          IDLE_LIMIT = 5000;
   localparam int          NUM_RANDOM = 400;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct packed {
      coord_type ax0, ay0, ax1, ay1;
      coord_type bx0, by0, bx1, by1;
   } pair_type;

   logic clock = 1'b0;
   logic reset;
   bit   steady;
   int   stall_left;
   int   idle_cycles;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned hit_count;

   segint_req_if #(.COORD_WIDTH(CW)) req_ch ();
   segint_rsp_if                     rsp_ch ();

   segment_intersection_test #(.COORD_WIDTH(CW)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   segint_checker #(.COORD_WIDTH(CW)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .hit_count     (hit_count)
   );

   always #6 clock = ~clock;

   // mostly short gaps, now and then a long one; none at all in steady stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int span(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic pair_type mk_pair(int ax0, int ay0, int ax1, int ay1,
                                        int bx0, int by0, int bx1, int by1);
      return '{coord_type'(ax0), coord_type'(ay0), coord_type'(ax1), coord_type'(ay1),
               coord_type'(bx0), coord_type'(by0), coord_type'(bx1), coord_type'(by1)};
   endfunction

   function automatic pair_type random_pair();
      int c[8];
      int edges[7];
      int kind, px, py, dx, dy, t, i;
      edges = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      kind  = $urandom_range(0, 99);
      if (kind < 20) begin
         for (i = 0; i < 8; i++) c[i] = span(-32768, 32767);
      end else if (kind < 60) begin
         // local grid: many touches, shared points and collinear triples
         px = span(-32000, 32000);
         py = span(-32000, 32000);
         for (i = 0; i < 8; i++) c[i] = ((i % 2 == 0) ? px : py) + span(-6, 6);
         if (kind >= 45) begin
            t = 2 * $urandom_range(0, 1);
            c[4] = c[t];
            c[5] = c[t + 1];
         end
      end else if (kind < 82) begin
         // all four points on one line
         px = span(-30000, 30000);
         py = span(-30000, 30000);
         dx = span(-20, 20);
         dy = span(-20, 20);
         for (i = 0; i < 4; i++) begin
            t = span(-10, 10);
            c[2*i]   = px + t * dx;
            c[2*i+1] = py + t * dy;
         end
         if (kind >= 75) begin
            c[2] = c[0];
            c[3] = c[1];
            if ($urandom_range(0, 1)) begin
               c[6] = c[4];
               c[7] = c[5];
            end
         end
      end else if (kind < 90) begin
         for (i = 0; i < 8; i++) c[i] = edges[$urandom_range(0, 6)];
      end else begin
         for (i = 0; i < 8; i++) c[i] = span(-32768, 32767);
         c[6] = (c[0] + c[2]) / 2;
         c[7] = (c[1] + c[3]) / 2;
      end
      return mk_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
   endfunction

   // leaves valid high at the accepting edge; a later call with a gap, or the caller, lowers it
   task automatic send_pair(input pair_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.first_start_x  <= p.ax0;
      req_ch.first_start_y  <= p.ay0;
      req_ch.first_end_x    <= p.ax1;
      req_ch.first_end_y    <= p.ay1;
      req_ch.second_start_x <= p.bx0;
      req_ch.second_start_y <= p.by0;
      req_ch.second_end_x   <= p.bx1;
      req_ch.second_end_y   <= p.by1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_ch.ready && !steady && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= pick_gap();
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, pending_count);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset                 = 1'b1;
      steady                = 1'b0;
      req_ch.valid          = 1'b0;
      req_ch.first_start_x  = '0;
      req_ch.first_start_y  = '0;
      req_ch.first_end_x    = '0;
      req_ch.first_end_y    = '0;
      req_ch.second_start_x = '0;
      req_ch.second_start_y = '0;
      req_ch.second_end_x   = '0;
      req_ch.second_end_y   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_pair(mk_pair(0, 0, 10, 10, 0, 10, 10, 0));                 // plain crossing
      send_pair(mk_pair(10, 0, 0, 10, 10, 10, 0, 0));                 // reversed crossing
      send_pair(mk_pair(0, 0, 10, 0, 0, 5, 10, 5));                   // parallel apart
      send_pair(mk_pair(0, 0, 10, 0, 5, 0, 5, 7));                    // T touch
      send_pair(mk_pair(0, 0, 4, 4, 4, 4, 9, 1));                     // shared end point
      send_pair(mk_pair(0, 0, 8, 0, 4, 0, 12, 0));                    // collinear overlap
      send_pair(mk_pair(0, 0, 3, 3, 5, 5, 9, 9));                     // collinear, disjoint
      send_pair(mk_pair(0, 0, 3, 3, 3, 3, 6, 6));                     // collinear, end to end
      send_pair(mk_pair(-10, -20, 10, 20, -1, -2, 1, 2));             // one inside the other
      send_pair(mk_pair(5, -3, 5, 3, 5, 2, 5, 9));                    // vertical overlap
      send_pair(mk_pair(2, 2, 2, 2, 0, 0, 4, 4));                     // point on segment
      send_pair(mk_pair(2, 3, 2, 3, 0, 0, 4, 4));                     // point off segment
      send_pair(mk_pair(7, -7, 7, -7, 7, -7, 7, -7));                 // same point twice
      send_pair(mk_pair(1, 1, 1, 1, 2, 2, 2, 2));                     // two distinct points
      send_pair(mk_pair(0, 0, 10, 0, 11, -5, 11, 5));                 // near miss
      send_pair(mk_pair(0, 0, 10, 10, 2, 5, 3, 9));                   // in box, off line
      send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      send_pair(mk_pair(-32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767));
      send_pair(mk_pair(-32768, 32767, 32767, 32767, -32768, 32766, 32767, 32766));
      send_pair(mk_pair(32767, 32767, -32768, -32768, -32768, 32767, -32768, 32767));
      send_pair(mk_pair(-1, -1, -1, -1, -32768, -32768, 32767, 32767));
      hold_until_drained();

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if ($urandom_range(0, 49) == 0) steady <= !steady;
         if (n == NUM_RANDOM / 2) hold_until_drained();
         send_pair(random_pair());
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Checked %0d segment pairs, %0d of them meeting: corner cases, grid-local,",
               checked_count, hit_count);
      $display("collinear, point-like and full-range pairs under random gaps and stalls");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
